/* sv/dda_pkg.sv */
package dda_pkg;

    // Default geometry
    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;

    // Item operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y
    } t_state;

endpackage

/* sv/dda_div.sv */
// Restoring divider for (mag << FRAC_BITS) / divisor with mag <= divisor.
// The quotient fits in FRAC_BITS+1 bits, one bit per cycle, integer bit first.
module dda_div #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_dividend,
    input  logic [COORD_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_quotient
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(FRAC_BITS);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [COORD_BITS:0]   r_rem, n_rem;
    logic [COORD_BITS-1:0] r_div, n_div;
    logic [FRAC_BITS:0]    r_quo, n_quo;

    logic [COORD_BITS+1:0] diff;
    logic                  ge;
    logic [COORD_BITS:0]   kept;

    // One trial subtraction per cycle
    always_comb begin
        diff = {1'b0, r_rem} - {2'b00, r_div};
        ge   = ~diff[COORD_BITS+1];
        kept = ge ? diff[COORD_BITS:0] : r_rem;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_TOP;
            n_rem  = {1'b0, i_dividend};
            n_div  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below divisor, so the dropped top bit is zero
            n_rem = {kept[COORD_BITS-1:0], 1'b0};
            n_quo = {r_quo[FRAC_BITS-1:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/dda_line_rasterizer.sv */
// DDA line rasterizer.
// Input channel (i_valid / o_stall): operation 0 starts a line from
// (start_x, start_y) to (end_x, end_y); operation 1 advances one pixel.
// Output channel (o_valid / i_stall): one pixel per transfer, o_last marks
// the end point of the line.
// A start transfer presents the start pixel on the output in the following cycle.
// If the endpoints differ, the input then stalls while one shared serial
// divider forms the x and y increments, one quotient bit per cycle.
// Advance transfers stream pixels at one per clock while the receiver
// does not stall; the increment add and the rounding add set that path.
// An advance with no line in progress is taken and gives no pixel.
// The output is a single register: when the receiver stalls, the pixel holds
// and the input stalls until it is taken.
// Synchronous reset clears the line state and the output valid.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);

    localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int STEP_BITS = FRAC_BITS + 2;

    dda_pkg::t_state r_state, n_state;

    logic [POS_BITS-1:0]   r_pos_x, r_pos_y;
    logic [STEP_BITS-1:0]  r_step_x, r_step_y;
    logic [COORD_BITS-1:0] r_steps_left;
    logic                  r_active;
    logic                  r_neg_x, r_neg_y;
    logic [COORD_BITS-1:0] r_ady, r_steps;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                  r_out_last;

    logic accept, out_free;
    logic is_start;

    logic [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0] adx, ady, steps;

    logic                  div_start;
    logic [COORD_BITS-1:0] div_dividend, div_divisor;
    logic                  div_done;
    logic [FRAC_BITS:0]    div_quo;
    logic [STEP_BITS-1:0]  inc, inc_neg;

    logic [POS_BITS-1:0]   nxt_pos_x, nxt_pos_y;
    logic [COORD_BITS-1:0] rnd_x, rnd_y;

    // Handshake
    assign out_free = ~r_out_valid | ~i_stall;
    assign o_stall  = (r_state != dda_pkg::S_IDLE) | ~out_free;
    assign accept   = i_valid & ~o_stall;
    assign is_start = (i_operation == dda_pkg::OP_START);

    // Deltas, magnitudes and step count
    always_comb begin
        dx    = {1'b0, i_end_x} - {1'b0, i_start_x};
        dy    = {1'b0, i_end_y} - {1'b0, i_start_y};
        adx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        steps = (adx > ady) ? adx : ady;
    end

    // Advance: new position and rounded pixel
    always_comb begin
        nxt_pos_x = r_pos_x + POS_BITS'($signed(r_step_x));
        nxt_pos_y = r_pos_y + POS_BITS'($signed(r_step_y));
        rnd_x     = nxt_pos_x[POS_BITS-1:FRAC_BITS] + COORD_BITS'(nxt_pos_x[FRAC_BITS-1]);
        rnd_y     = nxt_pos_y[POS_BITS-1:FRAC_BITS] + COORD_BITS'(nxt_pos_y[FRAC_BITS-1]);
    end

    // Signed increment from the unsigned quotient
    assign inc     = {1'b0, div_quo};
    assign inc_neg = -inc;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = r_ady;
        div_divisor  = r_steps;
        unique case (r_state)
            dda_pkg::S_IDLE: begin
                div_dividend = adx;
                div_divisor  = steps;
                if (accept && is_start && (steps != '0)) begin
                    div_start = 1'b1;
                    n_state   = dda_pkg::S_DIV_X;
                end
            end
            dda_pkg::S_DIV_X: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = dda_pkg::S_DIV_Y;
                end
            end
            dda_pkg::S_DIV_Y: begin
                if (div_done) begin
                    n_state = dda_pkg::S_IDLE;
                end
            end
            default: n_state = dda_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_steps_left <= '0;
            r_active     <= 1'b0;
        end else begin
            if (accept && is_start) begin
                r_pos_x      <= {i_start_x, FRAC_BITS'(0)};
                r_pos_y      <= {i_start_y, FRAC_BITS'(0)};
                r_step_x     <= '0;
                r_step_y     <= '0;
                r_steps_left <= steps;
                r_active     <= (steps != '0);
            end else if (accept && r_active) begin
                r_pos_x      <= nxt_pos_x;
                r_pos_y      <= nxt_pos_y;
                r_steps_left <= r_steps_left - 1'b1;
                if (r_steps_left == COORD_BITS'(1)) begin
                    r_active <= 1'b0;
                end
            end
            if (div_done && (r_state == dda_pkg::S_DIV_X)) begin
                r_step_x <= r_neg_x ? inc_neg : inc;
            end
            if (div_done && (r_state == dda_pkg::S_DIV_Y)) begin
                r_step_y <= r_neg_y ? inc_neg : inc;
            end
        end
    end

    // Operands kept for the second division and the signs
    always_ff @(posedge i_clk) begin
        if (accept && is_start) begin
            r_neg_x <= dx[COORD_BITS];
            r_neg_y <= dy[COORD_BITS];
            r_ady   <= ady;
            r_steps <= steps;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= accept & (is_start | r_active);
        end
        if (accept && is_start) begin
            r_out_x    <= i_start_x;
            r_out_y    <= i_start_y;
            r_out_last <= (steps == '0);
        end else if (accept && r_active) begin
            r_out_x    <= rnd_x;
            r_out_y    <= rnd_y;
            r_out_last <= (r_steps_left == COORD_BITS'(1));
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule

/* tb/sv/dda_line_checker.sv */
// Watches both channels of the rasterizer, predicts every pixel from the
// accepted input transfers and compares each output transfer with the oldest
// pending pixel.
module dda_line_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_operation,
    input  logic [dda_pkg::COORD_BITS-1:0] i_start_x,
    input  logic [dda_pkg::COORD_BITS-1:0] i_start_y,
    input  logic [dda_pkg::COORD_BITS-1:0] i_end_x,
    input  logic [dda_pkg::COORD_BITS-1:0] i_end_y,
    // output channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [dda_pkg::COORD_BITS-1:0] i_pixel_x,
    input  logic [dda_pkg::COORD_BITS-1:0] i_pixel_y,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pixels_pending
);

    localparam int COORD_BITS = dda_pkg::COORD_BITS;
    localparam int FRAC_BITS  = dda_pkg::FRAC_BITS;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int SUM_BITS   = POS_BITS + 1;
    localparam int INC_BITS   = FRAC_BITS + 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } t_pixel;

    t_pixel expected_pixels[$];

    // Shadow copy of the line state
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [INC_BITS-1:0]   inc_x;
    logic [INC_BITS-1:0]   inc_y;
    logic [COORD_BITS-1:0] steps_remaining;
    logic                  tracing;
    int                    failures;

    initial begin
        o_fail_count     = 0;
        o_pixels_pending = 0;
        failures         = 0;
    end

    // delta * 2^FRAC_BITS / span, truncated toward zero
    function automatic logic [INC_BITS-1:0] per_step_increment(int delta, int span);
        int magnitude;
        int quotient;
        magnitude = (delta < 0) ? -delta : delta;
        quotient  = (magnitude << FRAC_BITS) / span;
        return INC_BITS'((delta < 0) ? -quotient : quotient);
    endfunction

    // add one half, keep the integer part
    function automatic logic [COORD_BITS-1:0] round_to_pixel(logic [POS_BITS-1:0] pos);
        logic [SUM_BITS-1:0] sum;
        sum = {1'b0, pos} + SUM_BITS'(1 << (FRAC_BITS - 1));
        return sum[FRAC_BITS +: COORD_BITS];
    endfunction

    task automatic trace_item(logic op, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                              logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
        int     dx;
        int     dy;
        int     span;
        t_pixel pix;
        if (op == dda_pkg::OP_START) begin
            dx   = int'(ex) - int'(sx);
            dy   = int'(ey) - int'(sy);
            dx   = (dx < 0) ? -dx : dx;
            span = (dy < 0) ? -dy : dy;
            span = (dx > span) ? dx : span;
            dx   = int'(ex) - int'(sx);
            pos_x = '0;
            pos_y = '0;
            pos_x[FRAC_BITS +: COORD_BITS] = sx;
            pos_y[FRAC_BITS +: COORD_BITS] = sy;
            if (span == 0) begin
                // degenerate line: one pixel, stays idle
                inc_x           = '0;
                inc_y           = '0;
                steps_remaining = '0;
                tracing         = 1'b0;
            end else begin
                inc_x           = per_step_increment(dx, span);
                inc_y           = per_step_increment(dy, span);
                steps_remaining = COORD_BITS'(span);
                tracing         = 1'b1;
            end
            pix = '{x: sx, y: sy, last: (span == 0)};
            expected_pixels.push_back(pix);
        end else if (tracing) begin
            pos_x = pos_x + {{(POS_BITS-INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
            pos_y = pos_y + {{(POS_BITS-INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
            steps_remaining = steps_remaining - 1'b1;
            pix = '{x: round_to_pixel(pos_x), y: round_to_pixel(pos_y),
                    last: (steps_remaining == '0)};
            if (steps_remaining == '0)
                tracing = 1'b0;
            expected_pixels.push_back(pix);
        end
    endtask

    task automatic compare_field(string name, int want, int seen);
        if (want != seen) begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
        end
    endtask

    // Sample both channels at each edge
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            expected_pixels.delete();
            pos_x           = '0;
            pos_y           = '0;
            inc_x           = '0;
            inc_y           = '0;
            steps_remaining = '0;
            tracing         = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall)
                trace_item(i_operation, i_start_x, i_start_y, i_end_x, i_end_y);
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    failures++;
                    $display("%0t: pixel expected none actual (%0d,%0d) last %0d",
                             $time, i_pixel_x, i_pixel_y, i_last);
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("pixel_x", want.x, i_pixel_x);
                    compare_field("pixel_y", want.y, i_pixel_y);
                    compare_field("last", want.last, i_last);
                end
            end
        end
        o_fail_count     <= failures;
        o_pixels_pending <= expected_pixels.size();
    end

endmodule

/* tb/sv/tb_dda_line_rasterizer.sv */
// Stimulus and verdict for the line rasterizer; checking is in dda_line_checker.
module tb_dda_line_rasterizer;

    localparam int COORD_BITS   = dda_pkg::COORD_BITS;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_TAIL   = 100;
    localparam int SETTLE_TIME  = 60;
    localparam int MAX_COORD    = (1 << COORD_BITS) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_operation;
    logic [COORD_BITS-1:0] i_start_x;
    logic [COORD_BITS-1:0] i_start_y;
    logic [COORD_BITS-1:0] i_end_x;
    logic [COORD_BITS-1:0] i_end_y;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_BITS-1:0] o_pixel_x;
    logic [COORD_BITS-1:0] o_pixel_y;
    logic                  o_last;

    int fail_count;
    int pixels_pending;
    int items_sent;
    int gap_odds;
    bit idling_off;

    dda_line_rasterizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last)
    );

    dda_line_checker pixel_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_operation      (i_operation),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_pixel_x        (o_pixel_x),
        .i_pixel_y        (o_pixel_y),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pixels_pending (pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver backpressure: free runs with random stall bursts
    initial begin
        forever begin
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!idling_off && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COORD_BITS'(MAX_COORD);
            default: return COORD_BITS'($urandom_range(0, MAX_COORD));
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] base, int reach);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > MAX_COORD)
            v = MAX_COORD;
        return COORD_BITS'(v);
    endfunction

    function automatic int line_length(logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                                       logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
        int ax;
        int ay;
        ax = int'(ex) - int'(sx);
        ay = int'(ey) - int'(sy);
        ax = (ax < 0) ? -ax : ax;
        ay = (ay < 0) ? -ay : ay;
        return (ax > ay) ? ax : ay;
    endfunction

    // One input transfer, with an optional idle gap in front
    task automatic send_item(logic op, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                             logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
        if (!idling_off && $urandom_range(0, 3) < gap_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_start_x   <= sx;
        i_start_y   <= sy;
        i_end_x     <= ex;
        i_end_y     <= ey;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Endpoint fields carry noise on an advance
    task automatic advance(int count);
        repeat (count)
            send_item(dda_pkg::OP_ADVANCE, pick_coord(), pick_coord(), pick_coord(),
                      pick_coord());
    endtask

    task automatic draw_line(logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                             logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey,
                             int advances);
        send_item(dda_pkg::OP_START, sx, sy, ex, ey);
        advance(advances);
    endtask

    // Hold the sender until every predicted pixel has been seen
    task automatic wait_for_pixels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pixels_pending != 0);
    endtask

    initial begin
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        int span;
        int reach;
        int count;
        int directed_items;
        bit drained;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= dda_pkg::OP_START;
        i_start_x   <= '0;
        i_start_y   <= '0;
        i_end_x     <= '0;
        i_end_y     <= '0;
        idling_off  <= 1'b0;
        items_sent  = 0;
        gap_odds    = 1;
        drained     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: advance while idle, equal endpoints at both corners
        advance(1);
        draw_line('0, '0, '0, '0, 0);
        draw_line(COORD_BITS'(MAX_COORD), COORD_BITS'(MAX_COORD),
                  COORD_BITS'(MAX_COORD), COORD_BITS'(MAX_COORD), 0);
        // short steep line to its end, then one step past the end
        draw_line(COORD_BITS'(10), COORD_BITS'(10), COORD_BITS'(13), COORD_BITS'(5), 6);
        // full diagonals, each abandoned by the next start
        draw_line('0, '0, COORD_BITS'(MAX_COORD), COORD_BITS'(MAX_COORD), 3);
        draw_line(COORD_BITS'(MAX_COORD), '0, '0, COORD_BITS'(MAX_COORD), 3);
        draw_line('0, COORD_BITS'(MAX_COORD), COORD_BITS'(MAX_COORD), '0, 2);
        // one-pixel x and half-pixel y increments falling toward the origin
        draw_line(COORD_BITS'(4), COORD_BITS'(2), '0, '0, 4);
        directed_items = items_sent;

        // Random lines, mostly short and complete
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            if (!drained && items_sent >= directed_items + RANDOM_ITEMS / 2) begin
                wait_for_pixels();
                drained = 1'b1;
            end
            if (items_sent >= directed_items + RANDOM_ITEMS - QUIET_TAIL)
                idling_off <= 1'b1;
            gap_odds = $urandom_range(0, 2);
            sx = pick_coord();
            sy = pick_coord();
            case ($urandom_range(0, 19))
                0: advance(1);
                1: draw_line(sx, sy, pick_coord(), pick_coord(), $urandom_range(0, 8));
                2: draw_line(sx, sy, sx, sy, $urandom_range(0, 1));
                default: begin
                    reach = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40)
                                                        : $urandom_range(1, 4);
                    ex   = near_coord(sx, reach);
                    ey   = near_coord(sy, reach);
                    span = line_length(sx, sy, ex, ey);
                    count = $urandom_range(0, 9);
                    if (count < 7 || span == 0)
                        count = span;
                    else if (count < 9)
                        count = $urandom_range(0, span - 1);
                    else
                        count = span + $urandom_range(1, 3);
                    draw_line(sx, sy, ex, ey, count);
                end
            endcase
        end

        wait_for_pixels();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (fail_count == 0 && pixels_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
sv/dda_pkg.sv
sv/dda_div.sv
sv/dda_line_rasterizer.sv
tb/sv/dda_line_checker.sv
tb/sv/tb_dda_line_rasterizer.sv
